>>> design/eeg_headset_packet_parser_assert.svh
// Assertion macros shared by the packet parser modules.
`ifndef EEG_HEADSET_PACKET_PARSER_ASSERT_SVH
`define EEG_HEADSET_PACKET_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EEGP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EEGP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/eegp_pkg.sv
// Package with constants, types and helper functions of the EEG packet parser.
package eegp_pkg;

	localparam int unsigned NumQty = 13;

	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [7:0] EXCODE_BYTE = 8'h55;
	localparam logic [7:0] MAX_PAYLOAD = 8'd169;

	localparam logic [7:0] CODE_POOR  = 8'h02;
	localparam logic [7:0] CODE_ATTN  = 8'h04;
	localparam logic [7:0] CODE_MED   = 8'h05;
	localparam logic [7:0] CODE_BLINK = 8'h16;
	localparam logic [7:0] CODE_RAW   = 8'h80;
	localparam logic [7:0] CODE_BANDS = 8'h83;
	localparam logic [7:0] RAW_LEN    = 8'd2;
	localparam logic [7:0] BANDS_LEN  = 8'd24;

	localparam logic [3:0] QTY_POOR  = 4'd0;
	localparam logic [3:0] QTY_ATTN  = 4'd1;
	localparam logic [3:0] QTY_MED   = 4'd2;
	localparam logic [3:0] QTY_BLINK = 4'd3;
	localparam logic [3:0] QTY_RAW   = 4'd4;
	localparam logic [3:0] QTY_BAND0 = 4'd5;
	localparam logic [3:0] QTY_NONE  = 4'd13;

	localparam logic [NumQty-1:0] BAND_MARKS = 13'h1FE0;

	// Parse phases, shared by the controller and the datapath.
	localparam logic [2:0] PH_HUNT1  = 3'd0;
	localparam logic [2:0] PH_HUNT2  = 3'd1;
	localparam logic [2:0] PH_LENGTH = 3'd2;
	localparam logic [2:0] PH_CODE   = 3'd3;
	localparam logic [2:0] PH_VLEN   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_SKIP   = 3'd6;
	localparam logic [2:0] PH_CHECK  = 3'd7;

	typedef logic [NumQty-1:0] marks_t;

	typedef struct packed {
		logic       byte_en;
		logic       emit_load;
		logic [2:0] phase;
	} eegp_cmd_t;

	typedef struct packed {
		logic b_sync;
		logic b_zero;
		logic b_big;
		logic b_excode;
		logic b_ext;
		logic vlen_ok;
		logic last_payload;
		logic skip_done;
		logic row_done;
		logic out_free;
		logic emit_last;
	} eegp_status_t;

	function automatic logic [3:0] lowest_mark(input marks_t marks);
		logic [3:0] idx;
		idx = QTY_NONE;
		for (int i = NumQty - 1; i >= 0; i--) begin
			if (marks[i]) idx = 4'(i);
		end
		return idx;
	endfunction

	function automatic marks_t qty_bit(input logic [3:0] q);
		return marks_t'(1) << q;
	endfunction

endpackage

>>> design/eegp_datapath.sv
// Datapath of the EEG packet parser: counters, row decoding, shadow values and result register.
`include "eeg_headset_packet_parser_assert.svh"

module eegp_datapath import eegp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  eegp_cmd_t    cmd,
	input  logic [7:0]   rx_byte,
	output eegp_status_t status,
	input  logic         out_stall,
	output logic         out_valid,
	output logic [3:0]   quantity,
	output logic [23:0]  value,
	output logic         checksum_ok,
	output logic         last_of_packet
);

	logic [7:0]  bytes_left_q;
	logic [7:0]  payload_sum_q;
	logic [7:0]  row_code_q;
	logic [4:0]  row_position_q;
	logic [23:0] value_acc_q;
	logic [1:0]  triple_q;
	logic [2:0]  band_q;
	logic [23:0] shadow_q [NumQty];
	marks_t      marks_q;
	logic        emit_ok_q;
	logic        out_valid_q;
	logic [3:0]  quantity_q;
	logic [23:0] value_q;
	logic        checksum_ok_q;
	logic        last_q;

	logic [23:0] acc_shift;
	logic [4:0]  pos_next;
	logic [3:0]  short_idx;
	logic        short_known;
	logic        triple_full;
	logic        check_good;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [23:0] wr_data;
	marks_t      set_marks;
	logic [3:0]  emit_idx;
	logic        payload_phase;

	assign acc_shift     = {value_acc_q[15:0], rx_byte};
	assign pos_next      = row_position_q + 5'd1;
	assign triple_full   = (triple_q == 2'd2);
	assign check_good    = ((~payload_sum_q) == rx_byte);
	assign emit_idx      = lowest_mark(marks_q);
	assign payload_phase = (cmd.phase == PH_CODE) || (cmd.phase == PH_VLEN) ||
		(cmd.phase == PH_SKIP) || (cmd.phase == PH_DATA);

	always_comb begin
		short_known = 1'b1;
		case (row_code_q)
			CODE_POOR:  short_idx = QTY_POOR;
			CODE_ATTN:  short_idx = QTY_ATTN;
			CODE_MED:   short_idx = QTY_MED;
			CODE_BLINK: short_idx = QTY_BLINK;
			default: begin
				short_idx   = QTY_NONE;
				short_known = 1'b0;
			end
		endcase
	end

	// Shadow write and mark update for the data byte of a row.
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = short_idx;
		wr_data   = acc_shift;
		set_marks = '0;
		if (cmd.byte_en && cmd.phase == PH_DATA) begin
			if (!row_code_q[7]) begin
				wr_en = short_known;
				if (short_known) set_marks = qty_bit(short_idx);
			end else if (row_code_q == CODE_RAW) begin
				wr_addr = QTY_RAW;
				wr_data = {8'h00, acc_shift[15:0]};
				if (pos_next >= 5'd2) begin
					wr_en     = 1'b1;
					set_marks = qty_bit(QTY_RAW);
				end
			end else begin
				wr_addr = QTY_BAND0 + {1'b0, band_q};
				if (triple_full) begin
					wr_en = 1'b1;
					if (band_q == 3'd7) set_marks = BAND_MARKS;
				end
			end
		end
	end

	always_comb begin
		status.b_sync       = (rx_byte == SYNC_BYTE);
		status.b_zero       = (rx_byte == 8'd0);
		status.b_big        = (rx_byte > MAX_PAYLOAD);
		status.b_excode     = (rx_byte == EXCODE_BYTE);
		status.b_ext        = rx_byte[7];
		status.vlen_ok      = (row_code_q == CODE_RAW && rx_byte == RAW_LEN) ||
			(row_code_q == CODE_BANDS && rx_byte == BANDS_LEN);
		status.last_payload = (bytes_left_q == 8'd1);
		status.skip_done    = (value_acc_q == 24'd1);
		if (!row_code_q[7]) begin
			status.row_done = 1'b1;
		end else if (row_code_q == CODE_RAW) begin
			status.row_done = (pos_next >= 5'd2);
		end else begin
			status.row_done = triple_full && (band_q == 3'd7);
		end
		status.out_free  = !out_valid_q || !out_stall;
		status.emit_last = ((marks_q & (marks_q - marks_t'(1))) == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			case (cmd.phase)
				PH_LENGTH: begin
					if (!status.b_sync && !status.b_big) begin
						bytes_left_q  <= rx_byte;
						payload_sum_q <= 8'd0;
					end
				end
				PH_CHECK: begin
					payload_sum_q <= 8'd0;
					emit_ok_q     <= check_good;
				end
				PH_CODE, PH_VLEN, PH_SKIP, PH_DATA: begin
					payload_sum_q <= payload_sum_q + rx_byte;
					bytes_left_q  <= bytes_left_q - 8'd1;
					case (cmd.phase)
						PH_CODE: begin
							if (!status.b_excode) begin
								row_code_q     <= rx_byte;
								row_position_q <= 5'd0;
								value_acc_q    <= 24'd0;
								triple_q       <= 2'd0;
								band_q         <= 3'd0;
							end
						end
						PH_VLEN: begin
							if (!status.vlen_ok && !status.b_zero) begin
								value_acc_q <= {16'h0000, rx_byte};
							end
						end
						PH_SKIP: begin
							value_acc_q <= value_acc_q - 24'd1;
						end
						default: begin
							row_position_q <= pos_next;
							if (row_code_q[7] && row_code_q != CODE_RAW && triple_full) begin
								value_acc_q <= 24'd0;
								triple_q    <= 2'd0;
								band_q      <= band_q + 3'd1;
							end else begin
								value_acc_q <= acc_shift;
								triple_q    <= triple_q + 2'd1;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		if (wr_en) shadow_q[wr_addr] <= wr_data;
		if (cmd.emit_load) begin
			if (marks_q == '0) begin
				quantity_q    <= QTY_NONE;
				value_q       <= 24'd0;
				checksum_ok_q <= emit_ok_q;
				last_q        <= 1'b1;
			end else begin
				quantity_q    <= emit_idx;
				value_q       <= shadow_q[emit_idx];
				checksum_ok_q <= 1'b1;
				last_q        <= status.emit_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.byte_en) begin
				case (cmd.phase)
					PH_LENGTH: begin
						if (!status.b_sync && !status.b_big) marks_q <= '0;
					end
					PH_CHECK: begin
						if (!check_good) marks_q <= '0;
					end
					default: begin
						marks_q <= marks_q | set_marks;
					end
				endcase
			end else if (cmd.emit_load && marks_q != '0) begin
				marks_q <= marks_q & ~qty_bit(emit_idx);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign quantity       = quantity_q;
	assign value          = value_q;
	assign checksum_ok    = checksum_ok_q;
	assign last_of_packet = last_q;

	`EEGP_ASSERT_NOW(a_payload_count_live, cmd.byte_en && payload_phase, bytes_left_q != 8'd0, "payload word taken with no bytes left")
	`EEGP_ASSERT_NEXT(a_marks_remain, cmd.emit_load && !status.emit_last, marks_q != '0, "result not marked last but no marks remain")

endmodule

>>> design/eegp_ctrl.sv
// Controller of the EEG packet parser: parse phase and result emission sequencing.
`include "eeg_headset_packet_parser_assert.svh"

module eegp_ctrl import eegp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  eegp_status_t status,
	output eegp_cmd_t    cmd
);

	localparam logic MODE_PARSE = 1'b0;
	localparam logic MODE_EMIT  = 1'b1;

	logic       mode_q;
	logic [2:0] phase_q;
	logic       mode_d;
	logic [2:0] phase_d;
	logic       byte_en;
	logic       emit_load;

	assign in_stall  = (mode_q == MODE_EMIT);
	assign byte_en   = in_valid && !in_stall;
	assign emit_load = (mode_q == MODE_EMIT) && status.out_free;

	assign cmd.byte_en   = byte_en;
	assign cmd.emit_load = emit_load;
	assign cmd.phase     = phase_q;

	always_comb begin
		phase_d = phase_q;
		mode_d  = mode_q;
		if (byte_en) begin
			case (phase_q)
				PH_HUNT1: begin
					if (status.b_sync) phase_d = PH_HUNT2;
				end
				PH_HUNT2: begin
					phase_d = status.b_sync ? PH_LENGTH : PH_HUNT1;
				end
				PH_LENGTH: begin
					if (!status.b_sync) begin
						if (status.b_big) phase_d = PH_HUNT1;
						else if (status.b_zero) phase_d = PH_CHECK;
						else phase_d = PH_CODE;
					end
				end
				PH_CHECK: begin
					phase_d = PH_HUNT1;
					mode_d  = MODE_EMIT;
				end
				PH_CODE: begin
					if (!status.b_excode) phase_d = status.b_ext ? PH_VLEN : PH_DATA;
				end
				PH_VLEN: begin
					if (status.vlen_ok) phase_d = PH_DATA;
					else if (status.b_zero) phase_d = PH_CODE;
					else phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					if (status.skip_done) phase_d = PH_CODE;
				end
				default: begin
					if (status.row_done) phase_d = PH_CODE;
				end
			endcase
			if (phase_q != PH_HUNT1 && phase_q != PH_HUNT2 && phase_q != PH_LENGTH &&
				phase_q != PH_CHECK && status.last_payload) begin
				phase_d = PH_CHECK;
			end
		end
		if (emit_load && status.emit_last) mode_d = MODE_PARSE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PARSE;
			phase_q <= PH_HUNT1;
		end else begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
		end
	end

	`EEGP_ASSERT_NEXT(a_check_starts_emit, byte_en && phase_q == PH_CHECK, mode_q == MODE_EMIT && phase_q == PH_HUNT1, "checksum word did not start emission")
	`EEGP_ASSERT_NEXT(a_emit_ends, emit_load && status.emit_last, mode_q == MODE_PARSE, "emission did not end after last result")

endmodule

>>> design/eeg_headset_packet_parser.sv
// Top level of the EEG headset packet parser: controller plus datapath.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   rx_byte
//   output    out        out_valid / out_stall quantity, value, checksum_ok, last_of_packet
//
// While a packet is parsed, one input word is taken every cycle; sync, length and
// payload words are absorbed without producing anything.
// The checksum word starts an emission pass that gives one result per cycle, from
// one up to thirteen results, through a priority encoder over the update marks.
// During that pass the input is stalled; a stalled output holds the pass in place.
// After reset the parser hunts for the first sync word; no clearing pass is needed.
module eeg_headset_packet_parser import eegp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  quantity,
	output logic [23:0] value,
	output logic        checksum_ok,
	output logic        last_of_packet
);

	// Commands go from the controller to the datapath, status flags come back.
	eegp_cmd_t    cmd;
	eegp_status_t status;

	// The controller tracks the parse phase and decides when a result word
	// is loaded into the output register.
	eegp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the byte counters, the checksum sum, the row decoder,
	// the thirteen shadow values with their update marks and the result register.
	eegp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rx_byte        (rx_byte),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.quantity       (quantity),
		.value          (value),
		.checksum_ok    (checksum_ok),
		.last_of_packet (last_of_packet)
	);

endmodule

>>> bench/eegp_result_checker.sv
// Checker that predicts the parser's results from the accepted words and compares them.
module eegp_result_checker
	import eegp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  quantity,
	input  logic [23:0] value,
	input  logic        checksum_ok,
	input  logic        last_of_packet,
	output int          mismatches,
	output int          awaited,
	output int          readings_checked,
	output int          frames_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  qty;
		logic [23:0] val;
		logic        ok;
		logic        last;
	} reading_t;

	// Mirror of the parser's state.
	logic [2:0]  phase;
	logic [7:0]  left;
	logic [7:0]  sum;
	logic [7:0]  code;
	logic [4:0]  pos;
	logic [23:0] acc;
	logic [23:0] shadow [NumQty];
	marks_t      marks;

	reading_t expected_readings[$];

	task automatic decode_word(input logic [7:0] b);
		int idx;
		logic [4:0] band;
		if (phase == PH_HUNT1) begin
			if (b == SYNC_BYTE) phase = PH_HUNT2;
		end else if (phase == PH_HUNT2) begin
			phase = (b == SYNC_BYTE) ? PH_LENGTH : PH_HUNT1;
		end else if (phase == PH_LENGTH) begin
			if (b != SYNC_BYTE) begin
				if (b > MAX_PAYLOAD) begin
					phase = PH_HUNT1;
				end else begin
					left = b;
					sum = '0;
					marks = '0;
					phase = (b == 8'd0) ? PH_CHECK : PH_CODE;
				end
			end
		end else if (phase == PH_CHECK) begin
			frames_closed++;
			if (b != ~sum) begin
				expected_readings.push_back('{QTY_NONE, 24'd0, 1'b0, 1'b1});
			end else if (marks == '0) begin
				expected_readings.push_back('{QTY_NONE, 24'd0, 1'b1, 1'b1});
			end else begin
				for (int i = 0; i < NumQty; i++) begin
					if (marks[i])
						expected_readings.push_back('{4'(i), shadow[i], 1'b1,
							(marks >> (i + 1)) == '0});
				end
			end
			marks = '0;
			sum = '0;
			phase = PH_HUNT1;
		end else begin
			// Payload word.
			sum = sum + b;
			left = left - 8'd1;
			case (phase)
				PH_CODE: begin
					if (b != EXCODE_BYTE) begin
						code = b;
						pos = '0;
						acc = '0;
						phase = b[7] ? PH_VLEN : PH_DATA;
					end
				end
				PH_VLEN: begin
					if ((code == CODE_RAW && b == RAW_LEN) || (code == CODE_BANDS && b == BANDS_LEN))
						phase = PH_DATA;
					else if (b == 8'd0)
						phase = PH_CODE;
					else begin
						acc = {16'd0, b};
						phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					acc = acc - 24'd1;
					if (acc == '0) phase = PH_CODE;
				end
				default: begin
					acc = {acc[15:0], b};
					pos = pos + 5'd1;
					if (!code[7]) begin
						case (code)
							CODE_POOR:  idx = QTY_POOR;
							CODE_ATTN:  idx = QTY_ATTN;
							CODE_MED:   idx = QTY_MED;
							CODE_BLINK: idx = QTY_BLINK;
							default:    idx = NumQty;
						endcase
						if (idx < NumQty) begin
							shadow[idx] = acc;
							marks[idx] = 1'b1;
						end
						phase = PH_CODE;
					end else if (code == CODE_RAW) begin
						if (pos >= 5'd2) begin
							shadow[QTY_RAW] = {8'd0, acc[15:0]};
							marks[QTY_RAW] = 1'b1;
							phase = PH_CODE;
						end
					end else begin
						// Band powers: every third word closes one 24-bit value.
						if (pos % 3 == 0) begin
							band = pos / 3;
							if (band >= 5'd1 && band <= 5'd8) shadow[QTY_RAW + band] = acc;
							acc = '0;
						end
						if (pos >= 5'd24) begin
							marks = marks | BAND_MARKS;
							phase = PH_CODE;
						end
					end
				end
			endcase
			if (left == 8'd0) phase = PH_CHECK;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t seen, want;
		if (!arst_n) begin
			phase = PH_HUNT1;
			left = '0;
			sum = '0;
			code = '0;
			pos = '0;
			acc = '0;
			marks = '0;
			for (int i = 0; i < NumQty; i++) shadow[i] = '0;
			expected_readings.delete();
			mismatches = 0;
			readings_checked = 0;
			frames_closed = 0;
		end else begin
			if (in_valid && !in_stall) decode_word(rx_byte);
			if (out_valid && !out_stall) begin
				seen = '{quantity, value, checksum_ok, last_of_packet};
				if (expected_readings.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, actual quantity %0d value %0h ok %b last %b",
						$time, seen.qty, seen.val, seen.ok, seen.last);
				end else begin
					want = expected_readings.pop_front();
					readings_checked++;
					if (seen.qty !== want.qty) begin
						mismatches++;
						$display("%0t: quantity expected %0d, actual %0d", $time, want.qty, seen.qty);
					end
					if (seen.val !== want.val) begin
						mismatches++;
						$display("%0t: value of quantity %0d expected %0h, actual %0h",
							$time, want.qty, want.val, seen.val);
					end
					if (seen.ok !== want.ok) begin
						mismatches++;
						$display("%0t: checksum_ok expected %b, actual %b", $time, want.ok, seen.ok);
					end
					if (seen.last !== want.last) begin
						mismatches++;
						$display("%0t: last_of_packet of quantity %0d expected %b, actual %b",
							$time, want.qty, want.last, seen.last);
					end
				end
			end
		end
		awaited = expected_readings.size();
	end

endmodule

>>> bench/testbench.sv
// Top of the bench: clock, reset, packet stream stimulus and verdict for the packet parser.
module testbench import eegp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [3:0]  quantity;
	logic [23:0] value;
	logic        checksum_ok;
	logic        last_of_packet;

	int mismatches;
	int awaited;
	int readings_checked;
	int frames_closed;

	// The whole link stream is built up front and then played out word by word.
	logic [7:0] link_words[$];
	logic [7:0] payload[$];
	int         frames_built = 0;
	int         spoiled_frames = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	eeg_headset_packet_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quantity(quantity),
		.value(value),
		.checksum_ok(checksum_ok),
		.last_of_packet(last_of_packet)
	);

	eegp_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quantity(quantity),
		.value(value),
		.checksum_ok(checksum_ok),
		.last_of_packet(last_of_packet),
		.mismatches(mismatches),
		.awaited(awaited),
		.readings_checked(readings_checked),
		.frames_closed(frames_closed)
	);

	// Wraps the current payload into a frame: sync pair (plus extra syncs), length,
	// payload and checksum. A nonzero cut declares a shorter length than the rows
	// need, so the tail of the payload is never sent and the last row is truncated.
	// A spoiled frame carries a checksum that is off by a random nonzero pattern.
	task automatic add_frame(input int extra_syncs, input int cut, input bit spoil);
		logic [7:0] len;
		logic [7:0] sum;
		len = 8'(payload.size() - cut);
		sum = '0;
		repeat (2 + extra_syncs) link_words.push_back(SYNC_BYTE);
		link_words.push_back(len);
		for (int i = 0; i < len; i++) begin
			sum = sum + payload[i];
			link_words.push_back(payload[i]);
		end
		link_words.push_back(spoil ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
		payload.delete();
		frames_built++;
		if (spoil) spoiled_frames++;
	endtask

	// Appends one row of random kind and content to the payload. Well-formed rows
	// dominate; the rest are extended rows of unknown code or odd length and
	// stray extended-code words.
	task automatic add_random_row();
		int kind;
		logic [7:0] code;
		logic [7:0] span;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			case ($urandom_range(0, 4))
				0: code = CODE_POOR;
				1: code = CODE_ATTN;
				2: code = CODE_MED;
				3: code = CODE_BLINK;
				default: code = 8'($urandom_range(0, 127));
			endcase
			payload.push_back(code);
			payload.push_back(8'($urandom));
		end else if (kind < 55) begin
			payload.push_back(CODE_RAW);
			payload.push_back(RAW_LEN);
			repeat (2) payload.push_back(8'($urandom));
		end else if (kind < 70) begin
			payload.push_back(CODE_BANDS);
			payload.push_back(BANDS_LEN);
			repeat (24) payload.push_back(8'($urandom));
		end else if (kind < 85) begin
			// A long declared length runs past the words actually supplied, so the
			// skip swallows the following rows or is cut off by the payload end.
			case ($urandom_range(0, 2))
				0: code = CODE_RAW;
				1: code = CODE_BANDS;
				default: code = 8'($urandom_range(128, 255));
			endcase
			span = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
			payload.push_back(code);
			payload.push_back(span);
			repeat ((span > 8'd8) ? 8 : int'(span)) payload.push_back(8'($urandom));
		end else begin
			payload.push_back(EXCODE_BYTE);
		end
	endtask

	// Receiver: after each accepted result it stalls for a random number of cycles.
	// Now and then it switches into a calm stretch where it never stalls.
	initial begin
		int hold;
		bit rx_calm;
		hold = 0;
		rx_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
				hold = rx_calm ? 0 : $urandom_range(0, 5);
				out_stall <= (hold != 0);
			end else if (hold != 0) begin
				hold--;
				out_stall <= (hold != 0);
			end
		end
	end

	initial begin
		int kind;
		int rows;
		int cut;
		int gap;
		bit spoil;
		bit tx_calm;

		// Directed part. Noise first, including a lone sync that breaks the hunt.
		link_words = '{8'hFF, SYNC_BYTE, 8'h00};
		// Empty payload: the length word leads straight to the checksum, which
		// yields a single "none" result with a good checksum.
		add_frame(0, 0, 1'b0);
		// A third sync before the length, a repeated attention (the later value
		// wins), an extended-code word, a raw row with the wrong length and a row
		// of unknown code.
		payload = '{CODE_ATTN, 8'h00, EXCODE_BYTE, CODE_ATTN, 8'hFF,
			CODE_RAW, 8'h01, 8'h77, 8'h30, 8'h12};
		add_frame(1, 0, 1'b0);
		// Length just above the limit: the frame is dropped without a result.
		link_words.push_back(SYNC_BYTE);
		link_words.push_back(SYNC_BYTE);
		link_words.push_back(MAX_PAYLOAD + 8'd1);
		// Raw row truncated by the payload end, then a bad checksum.
		payload = '{CODE_POOR, 8'h00, CODE_RAW, RAW_LEN, 8'h12, 8'h34};
		add_frame(0, 1, 1'b1);

		// The largest legal payload: band powers plus one long unknown row that
		// fills the frame up to the length limit exactly.
		payload.push_back(CODE_BANDS);
		payload.push_back(BANDS_LEN);
		repeat (24) payload.push_back(8'($urandom));
		payload.push_back(8'($urandom_range(128, 255)));
		payload.push_back(MAX_PAYLOAD - 8'd28);
		repeat (int'(MAX_PAYLOAD) - 28) payload.push_back(8'($urandom));
		add_frame(0, 0, 1'b0);

		// Random part: mostly well-formed frames with random rows, some truncated
		// or with a spoiled checksum; the rest is noise, broken sync sequences,
		// oversize lengths and empty frames.
		while (link_words.size() < 330) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				rows = $urandom_range(1, 6);
				for (int r = 0; r < rows && payload.size() < 140; r++) add_random_row();
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, payload.size()) : 0;
				spoil = ($urandom_range(0, 9) == 0);
				add_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, cut, spoil);
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 4)) link_words.push_back(8'($urandom));
			end else if (kind < 90) begin
				link_words.push_back(SYNC_BYTE);
				if ($urandom_range(0, 1) == 0) begin
					link_words.push_back(8'($urandom));
				end else begin
					link_words.push_back(SYNC_BYTE);
					link_words.push_back(8'($urandom_range(int'(MAX_PAYLOAD) + 1, 255)));
				end
			end else begin
				add_frame($urandom_range(0, 2), 0, $urandom_range(0, 3) == 0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Play the stream out. Each word is preceded by a random gap, except in
		// calm stretches; valid stays high across back-to-back words and the word
		// is held until the parser takes it.
		tx_calm = 1'b0;
		foreach (link_words[i]) begin
			if ($urandom_range(0, 23) == 0) tx_calm = !tx_calm;
			gap = tx_calm ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			rx_byte <= link_words[i];
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;

		// Drain: wait until every predicted result has come out, then give the
		// parser a short while longer in case something unexpected follows.
		do @(negedge clk); while (awaited != 0);
		repeat (20) @(negedge clk);

		$display("Stream of %0d words: %0d frames built, %0d with a spoiled checksum.",
			link_words.size(), frames_built, spoiled_frames);
		$display("The parser closed %0d frames and %0d results were compared field by field.",
			frames_closed, readings_checked);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#200_000;
		$display("Timeout with %0d results still awaited.", awaited);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
